// File: hdl/lss_pkg.sv
`default_nettype none
package lss_pkg;

  // Built depth of the entry store
  localparam int DEPTH  = 256;
  localparam int ADDR_W = $clog2(DEPTH);
  // Field widths of the transaction
  localparam int KIND_W = 3;
  localparam int DATA_W = 32;
  localparam int CNT_W  = 9;

  typedef enum logic [KIND_W-1:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_PEEK   = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_SEARCH = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SEARCH,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage
`default_nettype wire

// File: hdl/lifo_stack_with_search.sv
// Bounded LIFO stack of signed 32-bit words with a linear search. Each input
// transaction carries one operation (push, pop, peek, clear, search) and
// produces exactly one result transaction with status, data, 1-based search
// position, count after the operation, and empty/full flags. The block takes
// one transaction at a time: in_stall_o is high from acceptance until the
// result moves into the output register. Push, clear, unknown codes and
// operations on an empty stack go straight to the done state; pop and peek
// first do one registered read of the entry RAM, and a search compares at
// most the current count of entries, stopping at a match: the single RAM
// read port and shared comparator see one entry per cycle, bottom first. A
// finished result waits in the output register while the next transaction
// is accepted. The capacity register (APB, address 0, reset 256) limits the
// usable depth to min(capacity, 256); write it only while the block is idle.
// Lowering it below the count keeps entries; push then fails and full_flag
// stays high. Unknown operation codes fail without touching the stack.
`default_nettype none
module lifo_stack_with_search (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // operation channel
  input  wire logic                              in_valid_i,
  output      logic                              in_stall_o,
  input  wire logic [lss_pkg::KIND_W-1:0]        kind_i,
  input  wire logic signed [lss_pkg::DATA_W-1:0] value_i,
  // result channel
  output      logic                              out_valid_o,
  input  wire logic                              out_stall_i,
  output      logic                              status_o,
  output      logic signed [lss_pkg::DATA_W-1:0] data_o,
  output      logic [lss_pkg::CNT_W-1:0]         position_o,
  output      logic [lss_pkg::CNT_W-1:0]         count_o,
  output      logic                              empty_flag_o,
  output      logic                              full_flag_o,
  // configuration port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [2:0]                        paddr,
  input  wire logic [31:0]                       pwdata,
  output      logic [31:0]                       prdata,
  output      logic                              pready
);

  logic [lss_pkg::CNT_W-1:0]  cap_q;
  logic                       cap_sel;
  lss_pkg::ram_req_t          ram_req;
  logic [lss_pkg::DATA_W-1:0] ram_rdata;

  // Only paddr[2] is decoded; addresses 0 to 3 all select the capacity register
  assign cap_sel = (paddr[2] == 1'b0);
  assign pready  = 1'b1;
  assign prdata  = cap_sel ? {{(32 - lss_pkg::CNT_W){1'b0}}, cap_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= lss_pkg::CNT_W'(256);
    end else if (psel && penable && pwrite && cap_sel) begin
      cap_q <= pwdata[lss_pkg::CNT_W-1:0];
    end
  end

  // Sequencer, count and shared comparator
  lss_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cap_i        (cap_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .data_o       (data_o),
    .position_o   (position_o),
    .count_o      (count_o),
    .empty_flag_o (empty_flag_o),
    .full_flag_o  (full_flag_o),
    .ram_req_o    (ram_req),
    .ram_rdata_i  (ram_rdata)
  );

  // Entry store; entries at or above the count are never used, so no clearing
  lss_ram #(
    .WIDTH (lss_pkg::DATA_W),
    .DEPTH (lss_pkg::DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

endmodule
`default_nettype wire

// File: hdl/lss_ram.sv
`default_nettype none
module lss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// File: hdl/lss_engine.sv
`default_nettype none
module lss_engine (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [lss_pkg::CNT_W-1:0]     cap_i,
  input  wire logic                          in_valid_i,
  output      logic                          in_stall_o,
  input  wire logic [lss_pkg::KIND_W-1:0]    kind_i,
  input  wire logic signed [lss_pkg::DATA_W-1:0] value_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_stall_i,
  output      logic                          status_o,
  output      logic signed [lss_pkg::DATA_W-1:0] data_o,
  output      logic [lss_pkg::CNT_W-1:0]     position_o,
  output      logic [lss_pkg::CNT_W-1:0]     count_o,
  output      logic                          empty_flag_o,
  output      logic                          full_flag_o,
  output      lss_pkg::ram_req_t             ram_req_o,
  input  wire logic [lss_pkg::DATA_W-1:0]    ram_rdata_i
);

  lss_pkg::state_e state_q, state_d;

  logic [lss_pkg::KIND_W-1:0] op_q;
  logic [lss_pkg::DATA_W-1:0] key_q;
  logic [lss_pkg::ADDR_W-1:0] idx_q;
  logic [lss_pkg::CNT_W-1:0]  count_q;
  logic                       res_status_q;
  logic [lss_pkg::DATA_W-1:0] res_data_q;
  logic [lss_pkg::CNT_W-1:0]  res_pos_q;
  logic                       out_valid_q;

  logic [lss_pkg::CNT_W-1:0] eff_cap;
  logic [lss_pkg::CNT_W-1:0] idx_next;
  logic                      accept;
  logic                      nonempty;
  logic                      can_push;
  logic                      hit;
  logic                      last;
  logic                      out_free;
  logic                      out_load;

  assign eff_cap  = (cap_i > lss_pkg::CNT_W'(lss_pkg::DEPTH)) ?
                    lss_pkg::CNT_W'(lss_pkg::DEPTH) : cap_i;
  assign accept   = (state_q == lss_pkg::ST_IDLE) && in_valid_i;
  assign nonempty = (count_q != '0);
  assign can_push = (count_q < eff_cap);
  // Shared comparator: the word read last cycle against the key
  assign hit      = (ram_rdata_i == key_q);
  assign idx_next = lss_pkg::CNT_W'(idx_q) + lss_pkg::CNT_W'(1);
  assign last     = (idx_next == count_q);
  assign out_free = !out_valid_q || !out_stall_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lss_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          unique case (kind_i) inside
            lss_pkg::OP_POP, lss_pkg::OP_PEEK:
              state_d = nonempty ? lss_pkg::ST_READ : lss_pkg::ST_DONE;
            lss_pkg::OP_SEARCH:
              state_d = nonempty ? lss_pkg::ST_SEARCH : lss_pkg::ST_DONE;
            default:
              state_d = lss_pkg::ST_DONE;
          endcase
        end
      end
      lss_pkg::ST_READ: begin
        state_d = lss_pkg::ST_DONE;
      end
      lss_pkg::ST_SEARCH: begin
        if (hit || last) begin
          state_d = lss_pkg::ST_DONE;
        end
      end
      lss_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = lss_pkg::ST_IDLE;
        end
      end
      default: state_d = lss_pkg::ST_IDLE;
    endcase
  end

  // Outputs: memory requests and result load
  always_comb begin
    ram_req_o.we    = 1'b0;
    ram_req_o.waddr = count_q[lss_pkg::ADDR_W-1:0];
    ram_req_o.wdata = value_i;
    ram_req_o.raddr = '0;
    out_load        = 1'b0;
    unique case (state_q)
      lss_pkg::ST_IDLE: begin
        if (in_valid_i && (kind_i == lss_pkg::OP_PUSH) && can_push) begin
          ram_req_o.we = 1'b1;
        end
        if (kind_i == lss_pkg::OP_POP || kind_i == lss_pkg::OP_PEEK) begin
          ram_req_o.raddr = lss_pkg::ADDR_W'(count_q - lss_pkg::CNT_W'(1));
        end
      end
      lss_pkg::ST_SEARCH: begin
        ram_req_o.raddr = idx_next[lss_pkg::ADDR_W-1:0];
      end
      lss_pkg::ST_DONE: begin
        out_load = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lss_pkg::ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        if (kind_i == lss_pkg::OP_PUSH && can_push) begin
          count_q <= count_q + lss_pkg::CNT_W'(1);
        end else if (kind_i == lss_pkg::OP_CLEAR) begin
          count_q <= '0;
        end
      end else if (state_q == lss_pkg::ST_READ && op_q == lss_pkg::OP_POP) begin
        count_q <= count_q - lss_pkg::CNT_W'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Transaction and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q         <= kind_i;
      key_q        <= value_i;
      idx_q        <= '0;
      res_data_q   <= '0;
      res_pos_q    <= '0;
      res_status_q <= !((kind_i == lss_pkg::OP_PUSH && can_push) ||
                        kind_i == lss_pkg::OP_CLEAR);
    end
    if (state_q == lss_pkg::ST_READ) begin
      res_status_q <= 1'b0;
      res_data_q   <= ram_rdata_i;
    end
    if (state_q == lss_pkg::ST_SEARCH) begin
      if (hit) begin
        res_status_q <= 1'b0;
        res_pos_q    <= idx_next;
      end else begin
        idx_q <= idx_next[lss_pkg::ADDR_W-1:0];
      end
    end
    if (out_load) begin
      status_o     <= res_status_q;
      data_o       <= res_data_q;
      position_o   <= res_pos_q;
      count_o      <= count_q;
      empty_flag_o <= !nonempty;
      full_flag_o  <= (count_q >= eff_cap);
    end
  end

  assign in_stall_o  = (state_q != lss_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// File: hdl/lss_checker.sv
`default_nettype none
module lss_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              in_valid_i,
  input wire logic                              in_stall_o,
  input wire logic [lss_pkg::KIND_W-1:0]        kind_i,
  input wire logic signed [lss_pkg::DATA_W-1:0] value_i,
  input wire logic                              out_valid_o,
  input wire logic                              out_stall_i,
  input wire logic                              status_o,
  input wire logic signed [lss_pkg::DATA_W-1:0] data_o,
  input wire logic [lss_pkg::CNT_W-1:0]         position_o,
  input wire logic [lss_pkg::CNT_W-1:0]         count_o,
  input wire logic                              empty_flag_o,
  input wire logic                              full_flag_o,
  input wire logic                              psel,
  input wire logic                              penable,
  input wire logic                              pwrite,
  input wire logic [2:0]                        paddr,
  input wire logic [31:0]                       pwdata,
  input wire logic [31:0]                       prdata,
  input wire logic                              pready
);

  // One transaction at a time: stall right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted while previous transaction in flight");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (empty_flag_o == (count_o == '0)))
    else $error("empty flag disagrees with count");

  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o) |-> (data_o == '0 && position_o == '0))
    else $error("failed result carries data or position");

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (position_o <= count_o))
    else $error("search position beyond count");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(data_o)))
    else $error("stalled result changed");

endmodule

bind lifo_stack_with_search lss_checker u_lss_checker (.*);
`default_nettype wire
